// ===== hw/rtl/gag_pkg.sv =====
// shared types and constants for the grid anchor generator
package gag_pkg;

    localparam int MAX_ANCHORS_DEF = 16;
    localparam int SLOT_LIMIT      = 16;
    localparam int GRID_LIMIT      = 1024;
    localparam int EDGE_W          = 16;
    localparam int OFS_W           = 20;
    localparam int CALC_W          = 22;
    localparam int POS_W           = 10;
    localparam int SLOT_W          = 4;
    localparam int CNT_W           = 5;
    localparam int PADDR_W         = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [2:0] REG_STRIDE      = 3'd0;
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd1;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [2:0] REG_STRADDLE    = 3'd5;
    localparam logic [2:0] REG_ANCHOR_CNT  = 3'd6;

    typedef logic signed [EDGE_W-1:0] t_edge;

    typedef struct packed {
        t_edge x_min;
        t_edge y_min;
        t_edge x_max;
        t_edge y_max;
    } t_box;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last_loc;
        logic              last_map;
        logic [OFS_W-1:0]  dx;
        logic [OFS_W-1:0]  dy;
    } t_issue;

endpackage

// ===== hw/rtl/grid_anchor_generator.sv =====
// top level of the grid anchor generator: config registers and item handshake
// Load up to 16 base anchor boxes first (opcode 0, one slot per item; slots at or beyond
// MAX_ANCHORS are dropped). Each emit item (opcode 1) steps a raster walk over the grid and
// yields anchor_count boxes, one per cycle from the table memory's single read port while
// the output takes them; anchor_count is clamped to 1..min(MAX_ANCHORS,16).
// The next item is taken in the cycle the last table read of an emit is issued; each result
// passes the read register, then the output register. Reading a slot never loaded returns
// undefined edges. Write registers only while no emit is in progress or pending at the output.
module grid_anchor_generator #(
    parameter int MAX_ANCHORS = gag_pkg::MAX_ANCHORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gag_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [3:0]                    i_entry_index,
    input  logic signed [15:0]            i_in_x_min,
    input  logic signed [15:0]            i_in_y_min,
    input  logic signed [15:0]            i_in_x_max,
    input  logic signed [15:0]            i_in_y_max,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_anchor_slot,
    output logic signed [15:0]            o_out_x_min,
    output logic signed [15:0]            o_out_y_min,
    output logic signed [15:0]            o_out_x_max,
    output logic signed [15:0]            o_out_y_max,
    output logic                          o_visible,
    output logic                          o_last_of_location,
    output logic                          o_last_of_map
);
    import gag_pkg::*;

    localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    logic [8:0]        r_stride;
    logic [10:0]       r_grid_width;
    logic [10:0]       r_grid_height;
    logic [12:0]       r_image_width;
    logic [12:0]       r_image_height;
    logic [10:0]       r_straddle;
    logic [CNT_W-1:0]  r_anchor_count;

    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic              in_acc;
    logic              start;
    logic              load;
    logic [AW+3:0]     wr_wide;
    t_box              wr_data;
    logic              busy;
    logic              last_issue;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    t_box              rd_data;
    logic              s1_valid;
    t_issue            s1;
    logic              out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride       <= 9'd16;
            r_grid_width   <= 11'd64;
            r_grid_height  <= 11'd64;
            r_image_width  <= 13'd1024;
            r_image_height <= 13'd1024;
            r_straddle     <= 11'd0;
            r_anchor_count <= CNT_W'(3);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_STRIDE:       r_stride       <= pwdata[8:0];
                REG_GRID_WIDTH:   r_grid_width   <= pwdata[10:0];
                REG_GRID_HEIGHT:  r_grid_height  <= pwdata[10:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[12:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[12:0];
                REG_STRADDLE:     r_straddle     <= pwdata[10:0];
                REG_ANCHOR_CNT:   r_anchor_count <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_STRIDE:       prdata = {23'd0, r_stride};
            REG_GRID_WIDTH:   prdata = {21'd0, r_grid_width};
            REG_GRID_HEIGHT:  prdata = {21'd0, r_grid_height};
            REG_IMAGE_WIDTH:  prdata = {19'd0, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {19'd0, r_image_height};
            REG_STRADDLE:     prdata = {21'd0, r_straddle};
            REG_ANCHOR_CNT:   prdata = {{(32-CNT_W){1'b0}}, r_anchor_count};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_in_ready = !busy || last_issue;
    assign in_acc     = i_in_valid && o_in_ready;
    assign start      = in_acc && (i_opcode == OP_EMIT);
    assign load       = in_acc && (i_opcode == OP_LOAD) &&
                        (7'(i_entry_index) < 7'(MAX_ANCHORS));
    assign wr_wide    = {{AW{1'b0}}, i_entry_index};

    assign wr_data.x_min = i_in_x_min;
    assign wr_data.y_min = i_in_y_min;
    assign wr_data.x_max = i_in_x_max;
    assign wr_data.y_max = i_in_y_max;

    gag_table #(
        .DEPTH (MAX_ANCHORS),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (load),
        .i_wr_addr (wr_wide[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gag_seq #(
        .MAX_ANCHORS (MAX_ANCHORS),
        .AW          (AW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_stride       (r_stride),
        .i_grid_width   (r_grid_width),
        .i_grid_height  (r_grid_height),
        .i_anchor_count (r_anchor_count),
        .i_out_free     (out_free),
        .o_busy         (busy),
        .o_last_issue   (last_issue),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .o_s1_valid     (s1_valid),
        .o_s1           (s1)
    );

    gag_box u_box (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_s1_valid         (s1_valid),
        .i_s1               (s1),
        .i_base             (rd_data),
        .i_image_width      (r_image_width),
        .i_image_height     (r_image_height),
        .i_straddle_thresh  ($signed(r_straddle)),
        .i_out_ready        (i_out_ready),
        .o_out_free         (out_free),
        .o_out_valid        (o_out_valid),
        .o_anchor_slot      (o_anchor_slot),
        .o_out_x_min        (o_out_x_min),
        .o_out_y_min        (o_out_y_min),
        .o_out_x_max        (o_out_x_max),
        .o_out_y_max        (o_out_y_max),
        .o_visible          (o_visible),
        .o_last_of_location (o_last_of_location),
        .o_last_of_map      (o_last_of_map)
    );

endmodule

// ===== hw/rtl/gag_table.sv =====
// base anchor table memory, one write port and one registered read port
module gag_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  gag_pkg::t_box       i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output gag_pkg::t_box       o_rd_data
);
    import gag_pkg::*;

    t_box r_mem [DEPTH];
    t_box r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/gag_seq.sv =====
// raster walk, grid offsets and per-anchor table read sequencing
module gag_seq #(
    parameter int MAX_ANCHORS = 16,
    parameter int AW          = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [8:0]                    i_stride,
    input  logic [10:0]                   i_grid_width,
    input  logic [10:0]                   i_grid_height,
    input  logic [gag_pkg::CNT_W-1:0]     i_anchor_count,
    input  logic                          i_out_free,
    output logic                          o_busy,
    output logic                          o_last_issue,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    output logic                          o_s1_valid,
    output gag_pkg::t_issue               o_s1
);
    import gag_pkg::*;

    localparam int CNT_LIMIT = (MAX_ANCHORS < SLOT_LIMIT) ? MAX_ANCHORS : SLOT_LIMIT;

    logic              r_busy;
    logic [SLOT_W-1:0] r_k;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [OFS_W-1:0]  r_dx;
    logic [OFS_W-1:0]  r_dy;
    logic              r_end_map;
    logic              r_s1_valid;
    t_issue            r_s1;

    logic [10:0]         gw;
    logic [10:0]         gh;
    logic [CNT_W-1:0]    cnt;
    logic                end_col;
    logic                end_row;
    logic [18:0]         prod_x;
    logic [18:0]         prod_y;
    logic                s1_free;
    logic                issue;
    logic                last;
    logic [AW+SLOT_W-1:0] k_wide;

    always_comb begin
        gw = i_grid_width;
        if (i_grid_width == 11'd0) begin
            gw = 11'd1;
        end else if (i_grid_width > 11'(GRID_LIMIT)) begin
            gw = 11'(GRID_LIMIT);
        end
        gh = i_grid_height;
        if (i_grid_height == 11'd0) begin
            gh = 11'd1;
        end else if (i_grid_height > 11'(GRID_LIMIT)) begin
            gh = 11'(GRID_LIMIT);
        end
        cnt = i_anchor_count;
        if (i_anchor_count == CNT_W'(0)) begin
            cnt = CNT_W'(1);
        end else if (i_anchor_count > CNT_W'(CNT_LIMIT)) begin
            cnt = CNT_W'(CNT_LIMIT);
        end
    end

    assign end_col = ({1'b0, r_col} + 11'd1) >= gw;
    assign end_row = ({1'b0, r_row} + 11'd1) >= gh;
    assign prod_x  = r_col * i_stride;
    assign prod_y  = r_row * i_stride;

    assign s1_free = !r_s1_valid || i_out_free;
    assign issue   = r_busy && s1_free;
    assign last    = (({1'b0, r_k}) + CNT_W'(1)) == cnt;
    assign k_wide  = {{AW{1'b0}}, r_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_k        <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_end_map  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_k <= r_k + SLOT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_start) begin
                r_busy    <= 1'b1;
                r_k       <= '0;
                r_end_map <= end_col && end_row;
                if (end_col) begin
                    r_col <= '0;
                    r_row <= end_row ? '0 : r_row + POS_W'(1);
                end else begin
                    r_col <= r_col + POS_W'(1);
                end
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (i_out_free) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx <= {prod_x, 1'b0};
            r_dy <= {prod_y, 1'b0};
        end
        if (issue) begin
            r_s1.slot     <= r_k;
            r_s1.last_loc <= last;
            r_s1.last_map <= last && r_end_map;
            r_s1.dx       <= r_dx;
            r_s1.dy       <= r_dy;
        end
    end

    assign o_busy       = r_busy;
    assign o_last_issue = issue && last;
    assign o_rd_en      = issue;
    assign o_rd_addr    = k_wide[AW-1:0];
    assign o_s1_valid   = r_s1_valid;
    assign o_s1         = r_s1;

endmodule

// ===== hw/rtl/gag_box.sv =====
// box shift, saturation, visibility test and output register
module gag_box (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    input  gag_pkg::t_issue             i_s1,
    input  gag_pkg::t_box               i_base,
    input  logic [12:0]                 i_image_width,
    input  logic [12:0]                 i_image_height,
    input  logic signed [10:0]          i_straddle_thresh,
    input  logic                        i_out_ready,
    output logic                        o_out_free,
    output logic                        o_out_valid,
    output logic [gag_pkg::SLOT_W-1:0]  o_anchor_slot,
    output logic signed [15:0]          o_out_x_min,
    output logic signed [15:0]          o_out_y_min,
    output logic signed [15:0]          o_out_x_max,
    output logic signed [15:0]          o_out_y_max,
    output logic                        o_visible,
    output logic                        o_last_of_location,
    output logic                        o_last_of_map
);
    import gag_pkg::*;

    function automatic logic signed [CALC_W-1:0] shift_edge(
        input t_edge            e,
        input logic [OFS_W-1:0] ofs
    );
        logic signed [CALC_W-1:0] a;
        logic signed [CALC_W-1:0] b;
        a = {{(CALC_W-EDGE_W){e[EDGE_W-1]}}, e};
        b = {{(CALC_W-OFS_W){1'b0}}, ofs};
        return a + b;
    endfunction

    function automatic t_edge sat_edge(input logic signed [CALC_W-1:0] v);
        t_edge r;
        r = v[EDGE_W-1:0];
        if (v > CALC_W'(signed'(32767))) begin
            r = 16'sh7FFF;
        end else if (v < -(CALC_W'(signed'(32768)))) begin
            r = 16'sh8000;
        end
        return r;
    endfunction

    logic                     r_valid;
    logic [SLOT_W-1:0]        r_slot;
    t_box                     r_box;
    logic                     r_visible;
    logic                     r_last_loc;
    logic                     r_last_map;

    logic signed [CALC_W-1:0] x0;
    logic signed [CALC_W-1:0] y0;
    logic signed [CALC_W-1:0] x1;
    logic signed [CALC_W-1:0] y1;
    logic signed [CALC_W-1:0] t_ext;
    logic signed [CALC_W-1:0] lim_lo;
    logic signed [CALC_W-1:0] lim_x;
    logic signed [CALC_W-1:0] lim_y;
    logic                     vis;
    logic                     out_free;

    always_comb begin
        x0     = shift_edge(i_base.x_min, i_s1.dx);
        y0     = shift_edge(i_base.y_min, i_s1.dy);
        x1     = shift_edge(i_base.x_max, i_s1.dx);
        y1     = shift_edge(i_base.y_max, i_s1.dy);
        t_ext  = {{(CALC_W-11){i_straddle_thresh[10]}}, i_straddle_thresh};
        lim_lo = -(t_ext <<< 1);
        lim_x  = ($signed({{(CALC_W-13){1'b0}}, i_image_width}) + t_ext) <<< 1;
        lim_y  = ($signed({{(CALC_W-13){1'b0}}, i_image_height}) + t_ext) <<< 1;
        vis    = i_straddle_thresh[10] ||
                 (x0 >= lim_lo && y0 >= lim_lo && x1 < lim_x && y1 < lim_y);
    end

    assign out_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && i_s1_valid) begin
            r_slot       <= i_s1.slot;
            r_box.x_min  <= sat_edge(x0);
            r_box.y_min  <= sat_edge(y0);
            r_box.x_max  <= sat_edge(x1);
            r_box.y_max  <= sat_edge(y1);
            r_visible    <= vis;
            r_last_loc   <= i_s1.last_loc;
            r_last_map   <= i_s1.last_map;
        end
    end

    assign o_out_free         = out_free;
    assign o_out_valid        = r_valid;
    assign o_anchor_slot      = r_slot;
    assign o_out_x_min        = r_box.x_min;
    assign o_out_y_min        = r_box.y_min;
    assign o_out_x_max        = r_box.x_max;
    assign o_out_y_max        = r_box.y_max;
    assign o_visible          = r_visible;
    assign o_last_of_location = r_last_loc;
    assign o_last_of_map      = r_last_map;

endmodule

// ===== sim/tb.sv =====
// testbench for grid_anchor_generator: table loads, raster walk, visibility and saturation
module tb;
    import gag_pkg::*;

    typedef struct {
        logic [3:0] slot;
        t_box       edges;
        logic       vis;
        logic       last_loc;
        logic       last_map;
    } t_anchor_box;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_opcode = OP_LOAD;
    logic [3:0]                i_entry_index = '0;
    logic signed [15:0]        i_in_x_min = '0;
    logic signed [15:0]        i_in_y_min = '0;
    logic signed [15:0]        i_in_x_max = '0;
    logic signed [15:0]        i_in_y_max = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [3:0]                o_anchor_slot;
    logic signed [15:0]        o_out_x_min;
    logic signed [15:0]        o_out_y_min;
    logic signed [15:0]        o_out_x_max;
    logic signed [15:0]        o_out_y_max;
    logic                      o_visible;
    logic                      o_last_of_location;
    logic                      o_last_of_map;

    grid_anchor_generator uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_opcode(i_opcode),
        .i_entry_index(i_entry_index),
        .i_in_x_min(i_in_x_min),
        .i_in_y_min(i_in_y_min),
        .i_in_x_max(i_in_x_max),
        .i_in_y_max(i_in_y_max),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_anchor_slot(o_anchor_slot),
        .o_out_x_min(o_out_x_min),
        .o_out_y_min(o_out_y_min),
        .o_out_x_max(o_out_x_max),
        .o_out_y_max(o_out_y_max),
        .o_visible(o_visible),
        .o_last_of_location(o_last_of_location),
        .o_last_of_map(o_last_of_map)
    );

    // predicted block state
    logic [8:0]         stride_r;
    logic [10:0]        grid_w_r;
    logic [10:0]        grid_h_r;
    logic [12:0]        img_w_r;
    logic [12:0]        img_h_r;
    logic signed [10:0] straddle_r;
    logic [4:0]         count_r;
    logic [9:0]         row_pos;
    logic [9:0]         col_pos;
    t_box               anchors [16];

    t_anchor_box pending_boxes [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void reset_model();
        stride_r   = 9'd16;
        grid_w_r   = 11'd64;
        grid_h_r   = 11'd64;
        img_w_r    = 13'd1024;
        img_h_r    = 13'd1024;
        straddle_r = 11'sd0;
        count_r    = 5'd3;
        row_pos    = '0;
        col_pos    = '0;
        for (int k = 0; k < 16; k++) anchors[k] = '0;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_STRIDE:       stride_r = value[8:0];
            REG_GRID_WIDTH:   grid_w_r = value[10:0];
            REG_GRID_HEIGHT:  grid_h_r = value[10:0];
            REG_IMAGE_WIDTH:  img_w_r = value[12:0];
            REG_IMAGE_HEIGHT: img_h_r = value[12:0];
            REG_STRADDLE:     straddle_r = value[10:0];
            REG_ANCHOR_CNT:   count_r = value[4:0];
            default: ;
        endcase
    endfunction

    function automatic t_edge sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_edge'(v);
    endfunction

    function automatic int clamp_grid(logic [10:0] g);
        if (g == 0) return 1;
        if (g > GRID_LIMIT) return GRID_LIMIT;
        return int'(g);
    endfunction

    function automatic void queue_expected(t_anchor_box b);
        pending_boxes.insert(pending_boxes.size(), b);
    endfunction

    // one box per base anchor slot below the clamped count at the current location, then step the walk
    function automatic void compute_location_boxes();
        int          cnt;
        int          gw;
        int          gh;
        longint      t;
        longint      dx;
        longint      dy;
        longint      x0;
        longint      y0;
        longint      x1;
        longint      y1;
        logic        end_col;
        logic        end_row;
        t_anchor_box b;
        cnt = int'(count_r);
        if (cnt == 0) cnt = 1;
        if (cnt > MAX_ANCHORS_DEF) cnt = MAX_ANCHORS_DEF;
        gw = clamp_grid(grid_w_r);
        gh = clamp_grid(grid_h_r);
        t = longint'(straddle_r);
        dx = 2 * longint'(col_pos) * longint'(stride_r);
        dy = 2 * longint'(row_pos) * longint'(stride_r);
        end_col = (int'(col_pos) + 1 >= gw);
        end_row = (int'(row_pos) + 1 >= gh);
        for (int k = 0; k < cnt; k++) begin
            x0 = longint'(anchors[k].x_min) + dx;
            y0 = longint'(anchors[k].y_min) + dy;
            x1 = longint'(anchors[k].x_max) + dx;
            y1 = longint'(anchors[k].y_max) + dy;
            b.slot = 4'(k);
            b.edges.x_min = sat16(x0);
            b.edges.y_min = sat16(y0);
            b.edges.x_max = sat16(x1);
            b.edges.y_max = sat16(y1);
            if (t >= 0) begin
                b.vis = (x0 >= -2 * t) && (y0 >= -2 * t) &&
                        (x1 < 2 * (longint'(img_w_r) + t)) &&
                        (y1 < 2 * (longint'(img_h_r) + t));
            end else begin
                b.vis = 1'b1;
            end
            b.last_loc = (k == cnt - 1);
            b.last_map = b.last_loc && end_col && end_row;
            queue_expected(b);
        end
        if (end_col) begin
            col_pos = '0;
            row_pos = end_row ? 10'd0 : row_pos + 10'd1;
        end else begin
            col_pos = col_pos + 10'd1;
        end
    endfunction

    function automatic t_box make_box(int x0, int y0, int x1, int y1);
        t_box b;
        b.x_min = t_edge'(x0);
        b.y_min = t_edge'(y0);
        b.x_max = t_edge'(x1);
        b.y_max = t_edge'(y1);
        return b;
    endfunction

    function automatic t_box random_box();
        t_box   b;
        longint t;
        longint d;
        int     s;
        case ($urandom_range(0, 2))
            0: b = {$urandom, $urandom};
            1: begin
                s = $urandom_range(0, 128);
                b.x_min = t_edge'(s - 64);
                s = $urandom_range(0, 128);
                b.y_min = t_edge'(s - 64);
                s = $urandom_range(0, 512);
                b.x_max = t_edge'(s - 64);
                s = $urandom_range(0, 512);
                b.y_max = t_edge'(s - 64);
            end
            default: begin
                // edges close to the visibility limits of the current setting
                t = (straddle_r < 0) ? longint'(0) : longint'(straddle_r);
                d = longint'($urandom_range(0, 3));
                b.x_min = sat16(-2 * t + d - 2);
                d = longint'($urandom_range(0, 3));
                b.y_min = sat16(-2 * t + d - 2);
                d = longint'($urandom_range(0, 3));
                b.x_max = sat16(2 * (longint'(img_w_r) + t) + d - 2);
                d = longint'($urandom_range(0, 3));
                b.y_max = sat16(2 * (longint'(img_h_r) + t) + d - 2);
            end
        endcase
        return b;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_anchor_box want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t unexpected box: expected none actual slot %0d",
                         $time, o_anchor_slot);
                mismatch_count++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("anchor_slot", {60'd0, want.slot}, {60'd0, o_anchor_slot});
                check_field("x_min", 64'(want.edges.x_min), 64'(o_out_x_min));
                check_field("y_min", 64'(want.edges.y_min), 64'(o_out_y_min));
                check_field("x_max", 64'(want.edges.x_max), 64'(o_out_x_max));
                check_field("y_max", 64'(want.edges.y_max), 64'(o_out_y_max));
                check_field("visible", {63'd0, want.vis}, {63'd0, o_visible});
                check_field("last_of_location", {63'd0, want.last_loc},
                            {63'd0, o_last_of_location});
                check_field("last_of_map", {63'd0, want.last_map}, {63'd0, o_last_of_map});
            end
        end
    end

    initial begin : out_stall_pattern
        int mode;
        int run;
        int stall_left;
        stall_left = 0;
        forever begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(20, 200);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) != 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            i_out_ready <= 1'b0;
                        end else if ($urandom_range(0, 5) == 0) begin
                            stall_left = $urandom_range(1, 6);
                            i_out_ready <= 1'b0;
                        end else begin
                            i_out_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_register(idx, value);
    endtask

    task automatic send_item(input logic op, input logic [3:0] slot, input t_box b);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (gaps_on) begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_entry_index <= slot;
        i_in_x_min <= b.x_min;
        i_in_y_min <= b.y_min;
        i_in_x_max <= b.x_max;
        i_in_y_max <= b.y_max;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (op == OP_LOAD) anchors[slot] = b;
        else compute_location_boxes();
    endtask

    task automatic emit_location();
        send_item(OP_EMIT, 4'($urandom), {$urandom, $urandom});
    endtask

    // wait until every box has come out, then let a trailing load finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_all(input int stride, input int gw, input int gh, input int iw,
                             input int ih, input int thr, input int cnt);
        write_reg(REG_STRIDE, 32'(stride));
        write_reg(REG_GRID_WIDTH, 32'(gw));
        write_reg(REG_GRID_HEIGHT, 32'(gh));
        write_reg(REG_IMAGE_WIDTH, 32'(iw));
        write_reg(REG_IMAGE_HEIGHT, 32'(ih));
        write_reg(REG_STRADDLE, {21'd0, 11'(thr)});
        write_reg(REG_ANCHOR_CNT, 32'(cnt));
    endtask

    task automatic test_table_load();
        t_box b;
        for (int k = 0; k < 16; k++) begin
            case (k)
                0: b = make_box(-32768, -32768, 32767, 32767);
                1: b = make_box(0, 0, 0, 0);
                2: b = make_box(-32, -32, 32, 32);
                3: b = make_box(32767, 32767, 32767, 32767);
                4: b = make_box(0, 0, 2047, 2047);
                5: b = make_box(-1, 0, 100, 100);
                6: b = make_box(0, 0, 2048, 100);
                7: b = make_box(0, -1, 100, 100);
                8: b = make_box(0, 0, 100, 2048);
                default: b = make_box(-16 * k, -8 * k, 16 * k, 8 * k);
            endcase
            send_item(OP_LOAD, 4'(k), b);
        end
        emit_location();
        emit_location();
        settle();
        write_reg(REG_ANCHOR_CNT, 32'd16);
        repeat (3) emit_location();
        settle();
    endtask

    task automatic test_config_extremes();
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: write_all(1, 1, 1, 1, 1, -1, 1);
                1: write_all(256, 1024, 1024, 8191, 8191, 1023, 16);
                2: write_all(0, 0, 0, 0, 0, 0, 0);
                3: write_all(511, 2047, 2047, 8191, 1, -1024, 31);
                default: write_all(16, 2, 2, 1024, 1024, 0, 3);
            endcase
            repeat (4) emit_location();
            send_item(OP_LOAD, 4'($urandom), random_box());
            settle();
        end
    endtask

    task automatic test_walk_wrap();
        write_all(8, 3, 2, 64, 64, 4, 2);
        repeat (14) emit_location();
        settle();
        // shrink the grid under the walk
        write_reg(REG_GRID_WIDTH, 32'd2);
        repeat (4) emit_location();
        settle();
        write_reg(REG_GRID_HEIGHT, 32'd1);
        repeat (3) emit_location();
        settle();
    endtask

    task automatic test_random_traffic();
        int thr;
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_STRIDE, ($urandom_range(0, 9) == 0) ?
                      32'($urandom_range(0, 511)) : 32'($urandom_range(1, 40)));
            write_reg(REG_GRID_WIDTH, ($urandom_range(0, 9) == 0) ?
                      32'($urandom_range(0, 2047)) : 32'($urandom_range(1, 6)));
            write_reg(REG_GRID_HEIGHT, ($urandom_range(0, 9) == 0) ?
                      32'($urandom_range(0, 2047)) : 32'($urandom_range(1, 6)));
            write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 1) == 0) ?
                      32'($urandom_range(1, 8191)) : 32'($urandom_range(1, 300)));
            write_reg(REG_IMAGE_HEIGHT, ($urandom_range(0, 1) == 0) ?
                      32'($urandom_range(1, 8191)) : 32'($urandom_range(1, 300)));
            case ($urandom_range(0, 3))
                0: thr = 11'h7ff;
                1: thr = $urandom_range(0, 2047);
                default: thr = $urandom_range(0, 64);
            endcase
            write_reg(REG_STRADDLE, 32'(thr));
            write_reg(REG_ANCHOR_CNT, ($urandom_range(0, 9) == 0) ?
                      32'($urandom_range(0, 31)) : 32'($urandom_range(1, 16)));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 27; n++) begin
                if ($urandom_range(0, 3) == 0) send_item(OP_LOAD, 4'($urandom), random_box());
                else emit_location();
            end
            settle();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_table_load();
        test_config_extremes();
        test_walk_wrap();
        test_random_traffic();
        settle();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
